### rtl/dst40_pkg.sv
// DST40 response cipher: shared widths, payload type, bit tables and round function.
// No dependencies; imported by dst40_round and dst40_response_cipher_core.
`timescale 1ns / 1ps

package dst40_pkg;

	localparam int STATE_W  = 40;
	localparam int KEY_W    = 40;
	localparam int RESP_W   = 24;
	localparam int RESP_LSB = 16;
	// key register steps after rounds 1, 4, 7, ...
	localparam int KEY_PERIOD = 3;
	localparam int KEY_PHASE  = 1;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [KEY_W-1:0]   key;
	} dst40_stage_t;

	// Bit tables, entry 0 at the left
	localparam logic [0:31] TAB_A = 32'b01011011_11001000_00110001_10101101;
	localparam logic [0:31] TAB_B = 32'b01100000_01101111_11110110_00000110;
	localparam logic [0:31] TAB_C = 32'b00101110_10111000_00111100_01010101;
	localparam logic [0:31] TAB_D = 32'b01011100_00111010_00111010_01011100;
	localparam logic [0:15] TAB_E = 16'b01010011_11001010;
	localparam logic [0:15] TAB_G = 16'b01110010_01001110;
	localparam logic [1:0] TAB_H [16] = '{
		2'd0,2'd0,2'd2,2'd3,2'd3,2'd1,2'd2,2'd1,
		2'd1,2'd2,2'd1,2'd3,2'd3,2'd2,2'd0,2'd0};

	// Two new state bits for one round
	function automatic logic [1:0] round_bits(input logic [STATE_W-1:0] s,
		input logic [KEY_W-1:0] k);
		logic g1, g2, g3, g4;
		logic [1:0] h;
		g1 = TAB_G[{TAB_A[{k[39], k[31], s[39], s[31], s[23]}],
			TAB_B[{k[38], k[30], s[38], s[30], s[22]}],
			TAB_C[{k[23], k[15], k[7], s[15], s[7]}],
			TAB_D[{k[22], k[14], k[6], s[14], s[6]}]}];
		g2 = TAB_G[{TAB_A[{k[37], k[29], s[37], s[29], s[21]}],
			TAB_B[{k[36], k[28], s[36], s[28], s[20]}],
			TAB_C[{k[21], k[13], k[5], s[13], s[5]}],
			TAB_D[{k[20], k[12], k[4], s[12], s[4]}]}];
		g3 = TAB_G[{TAB_A[{k[35], k[27], s[35], s[27], s[19]}],
			TAB_B[{k[34], k[26], s[34], s[26], s[18]}],
			TAB_C[{k[19], k[11], k[3], s[11], s[3]}],
			TAB_D[{k[18], k[10], k[2], s[10], s[2]}]}];
		g4 = TAB_G[{TAB_A[{k[33], k[25], s[33], s[25], s[17]}],
			TAB_B[{k[32], k[24], s[32], s[24], s[16]}],
			TAB_E[{k[17], k[9], k[1], s[9]}],
			TAB_E[{k[16], k[8], k[0], s[8]}]}];
		h = TAB_H[{g1, g2, g3, g4}];
		return h ^ s[1:0];
	endfunction

endpackage

### rtl/dst40_round.sv
// DST40 response cipher: one round as a registered pipeline stage.
// Depends on dst40_pkg (payload type, round function).
`timescale 1ns / 1ps

module dst40_round import dst40_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  dst40_stage_t in_data,
	input  logic         key_step,
	output logic         out_valid,
	output dst40_stage_t out_data
);

	logic         valid_s1;
	dst40_stage_t data_s1;
	dst40_stage_t next_data;
	logic [1:0]   nb;
	logic         fb;

	// round logic: new bits in at the top, key steps on selected rounds
	always_comb begin
		nb = round_bits(in_data.state, in_data.key);
		fb = in_data.key[0] ^ in_data.key[2] ^ in_data.key[19] ^ in_data.key[21];
		next_data.state = {nb, in_data.state[STATE_W-1:2]};
		if (key_step) begin
			next_data.key = {fb, in_data.key[KEY_W-1:1]};
		end else begin
			next_data.key = in_data.key;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		data_s1 <= next_data;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### rtl/dst40_response_cipher_core.sv
// DST40 response cipher top level: key register and a chain of round stages.
// Depends on dst40_pkg and dst40_round.
`timescale 1ns / 1ps

// Usage
//   Load the 40-bit key with key_we/key_wdata while no item is in flight; it
//   is sampled into the pipeline with every challenge.
//   Present an item by raising start for one cycle with challenge valid; the
//   item is taken when start is high and busy is low. busy is always low:
//   a new challenge may enter on every cycle.
//   The item passes through the registered round stages in order; done is high
//   in the cycle just before the edge that takes the result. One round is
//   computed per pipeline stage, so the chain has ROUNDS stages and
//   throughput is one item per cycle.
//   response is valid only in the single cycle that done is high; the
//   receiver must take it then, there is no back-pressure.
//   Reset (arst_n low) clears the key to zero and drops every item in the
//   pipeline; no done follows for items accepted before reset.

module dst40_response_cipher_core import dst40_pkg::*; #(
	parameter int ROUNDS = 192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_we,
	input  logic [KEY_W-1:0]   key_wdata,
	input  logic               start,
	input  logic [STATE_W-1:0] challenge,
	output logic               busy,
	output logic               done,
	output logic [RESP_W-1:0]  response
);

	logic [KEY_W-1:0] secret_key_q;
	logic             stage_valid [ROUNDS+1];
	dst40_stage_t     stage_data  [ROUNDS+1];

	// key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_key_q <= '0;
		end else if (key_we) begin
			secret_key_q <= key_wdata;
		end
	end

	// never stalls
	assign busy = 1'b0;

	// pipeline entry
	assign stage_valid[0]      = start;
	assign stage_data[0].state = challenge;
	assign stage_data[0].key   = secret_key_q;

	// one stage per round
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		dst40_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stage_valid[r]),
			.in_data  (stage_data[r]),
			.key_step ((r % KEY_PERIOD) == KEY_PHASE),
			.out_valid(stage_valid[r+1]),
			.out_data (stage_data[r+1])
		);
	end

	assign done     = stage_valid[ROUNDS];
	assign response = stage_data[ROUNDS].state[RESP_LSB +: RESP_W];

`ifndef SYNTH
	// every accepted item comes out of the last round stage as done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##ROUNDS done)
		else $error("item not delivered after ROUNDS cycles");

	// no result without a matching accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ROUNDS))
		else $error("result without a matching item");

	// the pipeline never refuses an item
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
`endif

endmodule
